[hdl/utf8_stream_decoder_unit_defines.svh]
// Assertion helpers for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// Checked only out of reset.
`define USD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define USD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/usd_pkg.sv]
package usd_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_NORMAL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLACED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRUNCATED = 2'd2;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [KIND_W-1:0] result_kind;
  } out_beat_t;

endpackage

[hdl/utf8_stream_decoder_unit.sv]
// UTF-8 stream decoder: one byte in, at most one code point out.
// Input channel: in_valid / in_stall / in_beat carry one byte per beat plus
// an end_of_string flag on the last byte of a string.
// Output channel: out_valid / out_stall / out_beat carry a 21-bit code point
// and a kind: normal, replacement (0xFFFD for a bad lead byte) or truncated
// (code point 0 when a string ends inside a sequence).
// Two registers deep: an accepted byte lands in the input register, is
// decoded there against the sequence state and its result is written to
// the output register once that register is free. Throughput is one byte
// per cycle while no stalled result blocks the input; the decode is a
// single pass of short logic between the two registers.
// Continuation bytes produce no beat unless they end a character or a
// string; a multi-byte character comes out with its last byte.
// Reset (rst_n low, synchronous) empties both registers and clears the
// pending count and partial code point.
// While out_stall holds a result, the output register keeps it; in_stall
// rises only once the input register also holds a byte with a result due.
`include "utf8_stream_decoder_unit_defines.svh"

module utf8_stream_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  usd_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output usd_pkg::out_beat_t out_beat
);

  logic               s1_vld_r;
  usd_pkg::in_beat_t  s1_r;
  logic               out_vld_r;
  usd_pkg::out_beat_t out_r;
  logic [1:0]         pending_r;
  logic [usd_pkg::CP_W-1:0] partial_r;

  logic [1:0]         pending_nxt;
  logic [usd_pkg::CP_W-1:0] partial_nxt;
  logic               emit;
  usd_pkg::out_beat_t res;
  logic               out_free;
  logic               s1_adv;

  // Decode of the byte held in the input register.
  always_comb begin
    pending_nxt     = pending_r;
    partial_nxt     = partial_r;
    emit            = 1'b0;
    res.code_point  = '0;
    res.result_kind = usd_pkg::KIND_NORMAL;
    if (pending_r != 2'd0) begin
      // any byte counts as continuation while a sequence is open
      partial_nxt = {partial_r[usd_pkg::CP_W-7:0], s1_r.data_byte[5:0]};
      pending_nxt = pending_r - 2'd1;
      if (pending_nxt == 2'd0) begin
        emit           = 1'b1;
        res.code_point = partial_nxt;
        partial_nxt    = '0;
      end else if (s1_r.end_of_string) begin
        emit            = 1'b1;
        res.result_kind = usd_pkg::KIND_TRUNCATED;
        pending_nxt     = 2'd0;
        partial_nxt     = '0;
      end
    end else begin
      unique case (s1_r.data_byte) inside
        8'b0???????: begin
          emit           = 1'b1;
          res.code_point = {13'd0, s1_r.data_byte};
        end
        8'b110?????: begin
          partial_nxt = {16'd0, s1_r.data_byte[4:0]};
          pending_nxt = 2'd1;
        end
        8'b1110????: begin
          partial_nxt = {17'd0, s1_r.data_byte[3:0]};
          pending_nxt = 2'd2;
        end
        8'b11110???: begin
          partial_nxt = {18'd0, s1_r.data_byte[2:0]};
          pending_nxt = 2'd3;
        end
        default: begin
          emit            = 1'b1;
          res.code_point  = usd_pkg::REPLACEMENT_CP;
          res.result_kind = usd_pkg::KIND_REPLACED;
        end
      endcase
      // lead byte flagged last: truncated, nothing stays open
      if (pending_nxt != 2'd0 && s1_r.end_of_string) begin
        emit            = 1'b1;
        res.code_point  = '0;
        res.result_kind = usd_pkg::KIND_TRUNCATED;
        pending_nxt     = 2'd0;
        partial_nxt     = '0;
      end
    end
  end

  assign out_free  = !out_vld_r || !out_stall;
  assign s1_adv    = s1_vld_r && (!emit || out_free);
  assign in_stall  = s1_vld_r && !s1_adv;
  assign out_valid = out_vld_r;
  assign out_beat  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pending_r <= 2'd0;
      partial_r <= '0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (s1_adv) begin
        pending_r <= pending_nxt;
        partial_r <= partial_nxt;
      end
      if (out_free) begin
        out_vld_r <= s1_adv && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_r <= in_beat;
    end
    if (out_free && s1_adv && emit) begin
      out_r <= res;
    end
  end

  `USD_ASSERT_ALWAYS(a_idle_partial_clear,
    (pending_r == 2'd0) |-> (partial_r == '0),
    "partial code point left with no sequence open")
  `USD_ASSERT(a_repl_value,
    (out_vld_r && out_r.result_kind == usd_pkg::KIND_REPLACED) |->
      (out_r.code_point == usd_pkg::REPLACEMENT_CP),
    "replacement kind without 0xFFFD")
  `USD_ASSERT(a_trunc_value,
    (out_vld_r && out_r.result_kind == usd_pkg::KIND_TRUNCATED) |->
      (out_r.code_point == '0),
    "truncated kind with nonzero code point")
  `USD_ASSERT(a_kind_range,
    out_vld_r |-> (out_r.result_kind <= usd_pkg::KIND_TRUNCATED),
    "undefined result kind")
  `USD_ASSERT(a_stall_cause,
    in_stall |-> (s1_vld_r && emit && out_vld_r && out_stall),
    "input stalled without a blocked result")
  `USD_ASSERT(a_seq_after_trunc,
    (s1_adv && emit && res.result_kind == usd_pkg::KIND_TRUNCATED) |=>
      (pending_r == 2'd0),
    "sequence still open after truncation")

endmodule

[tb/sv/usd_stream_checker.sv]
`timescale 1ns / 100ps

module usd_stream_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  usd_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_stall,
  input  usd_pkg::out_beat_t out_beat,
  output int unsigned        fail_count,
  output int unsigned        backlog
);

  logic [1:0]               cont_left  = '0;
  logic [usd_pkg::CP_W-1:0] partial_cp = '0;
  usd_pkg::out_beat_t       cp_queue[$];
  int unsigned              fails = 0;

  // Advances the decode state by one byte; returns 1 when a code point is due.
  function automatic bit decode_byte(input usd_pkg::in_beat_t beat,
                                     output usd_pkg::out_beat_t res);
    logic [7:0] b;
    b   = beat.data_byte;
    res = '0;
    if (cont_left != 2'd0) begin
      // top two bits of a continuation byte are not checked
      partial_cp = {partial_cp[usd_pkg::CP_W-7:0], b[5:0]};
      cont_left  = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        res.code_point  = partial_cp;
        res.result_kind = usd_pkg::KIND_NORMAL;
        partial_cp      = '0;
        return 1'b1;
      end
      if (beat.end_of_string) begin
        cont_left       = '0;
        partial_cp      = '0;
        res.result_kind = usd_pkg::KIND_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!b[7]) begin
      res.code_point  = {{(usd_pkg::CP_W-8){1'b0}}, b};
      res.result_kind = usd_pkg::KIND_NORMAL;
      return 1'b1;
    end
    casez (b)
      8'b110?????: begin
        partial_cp = {{(usd_pkg::CP_W-5){1'b0}}, b[4:0]};
        cont_left  = 2'd1;
      end
      8'b1110????: begin
        partial_cp = {{(usd_pkg::CP_W-4){1'b0}}, b[3:0]};
        cont_left  = 2'd2;
      end
      8'b11110???: begin
        partial_cp = {{(usd_pkg::CP_W-3){1'b0}}, b[2:0]};
        cont_left  = 2'd3;
      end
      default: begin
        res.code_point  = usd_pkg::REPLACEMENT_CP;
        res.result_kind = usd_pkg::KIND_REPLACED;
        return 1'b1;
      end
    endcase
    if (beat.end_of_string) begin
      cont_left       = '0;
      partial_cp      = '0;
      res.result_kind = usd_pkg::KIND_TRUNCATED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    usd_pkg::out_beat_t want;
    usd_pkg::out_beat_t pred;
    if (!rst_n) begin
      cont_left  = '0;
      partial_cp = '0;
      cp_queue.delete();
    end else begin
      // compare before predicting: a result always belongs to an older beat
      if (out_valid && !out_stall) begin
        if (cp_queue.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got cp %h kind %0d",
                   $time, out_beat.code_point, out_beat.result_kind);
        end else begin
          want = cp_queue.pop_front();
          if (want.code_point !== out_beat.code_point ||
              want.result_kind !== out_beat.result_kind) begin
            fails++;
            $display("%0t: result mismatch, expected cp %h kind %0d, got cp %h kind %0d",
                     $time, want.code_point, want.result_kind,
                     out_beat.code_point, out_beat.result_kind);
          end
        end
      end
      if (in_valid && !in_stall && decode_byte(in_beat, pred))
        cp_queue.push_back(pred);
    end
    backlog    = cp_queue.size();
    fail_count = fails;
  end

endmodule

[tb/sv/utf8_stream_decoder_unit_tb.sv]
`timescale 1ns / 100ps

module utf8_stream_decoder_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  // {end_of_string, data_byte}
  localparam logic [8:0] DIRECTED_BYTES [25] = '{
    9'h000, 9'h17F,                     // ASCII extremes, second one ends a string
    9'h0C2, 9'h0A9,                     // 2-byte form
    9'h0E2, 9'h082, 9'h0AC,             // 3-byte form
    9'h0F0, 9'h09F, 9'h098, 9'h080,     // 4-byte form
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,     // largest 21-bit value, completes on last byte
    9'h080, 9'h0FF, 9'h0F8,             // bad leads
    9'h1C3,                             // lead byte closing a string
    9'h0E2, 9'h182,                     // string ends mid sequence
    9'h0C3, 9'h0FF,                     // lead-looking byte taken as continuation
    9'h1F0, 9'h1E0                      // 4- and 3-byte leads closing a string
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  usd_pkg::in_beat_t   in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  usd_pkg::out_beat_t  out_beat;

  int unsigned fail_count;
  int unsigned backlog;
  int unsigned idle_pct = 32;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;

  utf8_stream_decoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  usd_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{data_byte: b, end_of_string: eos};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // One character of the given length, sometimes cut short by an end of string.
  task automatic send_char(input int unsigned len);
    logic [7:0]  lead;
    logic [7:0]  cont;
    int unsigned stop_at;
    bit          eos;
    stop_at = len;
    if (len > 1 && $urandom_range(99) < 10)
      stop_at = $urandom_range(len - 1, 1);
    eos  = (stop_at < len) || ($urandom_range(99) < 15);
    lead = 8'($urandom_range(255));
    case (len)
      1: lead[7] = 1'b0;
      2: lead[7:5] = 3'b110;
      3: lead[7:4] = 4'b1110;
      default: lead[7:3] = 5'b11110;
    endcase
    push_beat(lead, eos && stop_at == 1);
    for (int i = 2; i <= stop_at; i++) begin
      cont = 8'($urandom_range(255));
      if ($urandom_range(99) < 90)
        cont[7:6] = 2'b10;
      push_beat(cont, eos && i == stop_at);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_BYTES[i])
      push_beat(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

    while (bytes_sent < RANDOM_BYTES + $size(DIRECTED_BYTES)) begin
      // a stretch with no idling on either side
      idle_pct = (bytes_sent >= 200 && bytes_sent < 300) ? 0 : 32;
      if ($urandom_range(99) < 75)
        send_char($urandom_range(4, 1));
      else
        push_beat(8'($urandom_range(255)), $urandom_range(99) < 20);
    end
    in_valid <= 1'b0;

    // read the checker's backlog away from the edge it updates on
    do @(negedge clk); while (backlog != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
